>>> hw/rtl/mdd_pkg.sv
package mdd_pkg;

    // payload limit per frame and the width of the payload counter
    localparam int MAX_PAYLOAD = 256;
    localparam int COUNT_W     = $clog2(MAX_PAYLOAD + 1);

    localparam int BYTE_W      = 8;
    localparam int MARKER_W    = 32;
    localparam int HISTORY_W   = 24;
    localparam int TICK_W      = 16;
    localparam int KIND_W      = 2;
    localparam int LEN_W       = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int HELD_W      = 2;

    localparam logic [HELD_W-1:0] HELD_FULL = HELD_W'(3);
    localparam logic [TICK_W-1:0] TICK_MAX  = {TICK_W{1'b1}};

    // result kinds
    localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd3;

    // item kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STOP_MARKER   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT_TICKS = 2'd2;

    localparam logic [MARKER_W-1:0] START_MARKER_RST  = 32'h7878_7878;
    localparam logic [MARKER_W-1:0] STOP_MARKER_RST   = 32'h6161_3535;
    localparam logic [TICK_W-1:0]   TIMEOUT_TICKS_RST = 16'd100;

    typedef struct packed {
        logic [MARKER_W-1:0] start_marker;
        logic [MARKER_W-1:0] stop_marker;
        logic [TICK_W-1:0]   timeout_ticks;
    } mdd_cfg_t;

    typedef struct packed {
        logic                 in_frame;
        logic [HISTORY_W-1:0] recent_bytes;
        logic [HELD_W-1:0]    held_count;
        logic [COUNT_W-1:0]   payload_count;
        logic [TICK_W-1:0]    tick_count;
    } mdd_state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  frame_length;
    } mdd_result_t;

    localparam mdd_state_t STATE_RST = '0;

endpackage

>>> hw/rtl/mdd_channels.sv
interface mdd_in_if;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic [mdd_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface mdd_out_if;
    logic                       valid;
    logic                       ready;
    logic [mdd_pkg::KIND_W-1:0] kind;
    logic [mdd_pkg::BYTE_W-1:0] payload_byte;
    logic [mdd_pkg::LEN_W-1:0]  frame_length;

    modport source (output valid, output kind, output payload_byte, output frame_length,
                    input ready);
    modport sink (input valid, input kind, input payload_byte, input frame_length,
                  output ready);
endinterface

>>> hw/rtl/mdd_step.sv
module mdd_step (
    input  mdd_pkg::mdd_cfg_t                cfg,
    input  mdd_pkg::mdd_state_t              state,
    input  logic                             cmd,
    input  logic [mdd_pkg::BYTE_W-1:0]       rx_byte,
    output mdd_pkg::mdd_state_t              state_next,
    output logic                             res_valid,
    output mdd_pkg::mdd_result_t             res
);
    import mdd_pkg::*;

    logic [MARKER_W-1:0]  window;
    logic [TICK_W-1:0]    tick_inc;
    mdd_state_t           pushed;

    assign window   = {state.recent_bytes, rx_byte};
    assign tick_inc = (state.tick_count < TICK_MAX) ? state.tick_count + 1'b1
                                                    : state.tick_count;

    // state with the new byte shifted into the history
    always_comb
    begin
        pushed              = state;
        pushed.recent_bytes = {state.recent_bytes[HISTORY_W-BYTE_W-1:0], rx_byte};
        if (state.held_count < HELD_FULL)
        begin
            pushed.held_count = state.held_count + 1'b1;
        end
    end

    always_comb
    begin
        state_next = state;
        res_valid  = 1'b0;
        res        = '0;
        unique case (cmd)
            CMD_TICK:
            begin
                state_next.tick_count = tick_inc;
                if (tick_inc >= cfg.timeout_ticks)
                begin
                    state_next = STATE_RST;
                    res_valid  = 1'b1;
                    res.kind   = KIND_TIMEOUT;
                end
            end
            CMD_BYTE:
            begin
                if (!state.in_frame)
                begin
                    if (state.held_count == HELD_FULL && window == cfg.start_marker)
                    begin
                        state_next.in_frame      = 1'b1;
                        state_next.recent_bytes  = '0;
                        state_next.held_count    = '0;
                        state_next.payload_count = '0;
                    end
                    else
                    begin
                        state_next = pushed;
                    end
                end
                else
                begin
                    priority if (state.held_count == HELD_FULL && window == cfg.stop_marker)
                    begin
                        state_next       = STATE_RST;
                        res_valid        = 1'b1;
                        res.kind         = KIND_END;
                        res.frame_length = LEN_W'(state.payload_count);
                    end
                    else if (state.held_count < HELD_FULL)
                    begin
                        state_next = pushed;
                    end
                    else if (state.payload_count >= COUNT_W'(MAX_PAYLOAD))
                    begin
                        state_next = STATE_RST;
                        res_valid  = 1'b1;
                        res.kind   = KIND_OVERFLOW;
                    end
                    else
                    begin
                        state_next               = pushed;
                        state_next.payload_count = state.payload_count + 1'b1;
                        res_valid                = 1'b1;
                        res.kind                 = KIND_PAYLOAD;
                        res.payload_byte         = state.recent_bytes[HISTORY_W-1 -: BYTE_W];
                    end
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

>>> hw/rtl/marker_delimited_deframer_top.sv
// channel   dir  handshake     payload
// in_ch     in   valid/ready   cmd, rx_byte
// out_ch    out  valid/ready   kind, payload_byte, frame_length
// cfg       in   cfg_we        cfg_index, cfg_data (no read-back)
//
// one item per cycle while out_ch is not stalled: an input register feeds the marker
// compare and counter update, whose result lands in the output register in the same cycle
// an input transaction passes the input register, then the output register, to out_ch
// rst_n clears the frame state, the valid flags and restores register defaults
// a stalled out_ch holds its result; the input register takes one more item
// and in_ch ready then follows out_ch ready
module marker_delimited_deframer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    mdd_in_if.sink                             in_ch,
    mdd_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [mdd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mdd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mdd_pkg::*;

    mdd_cfg_t               cfg_reg;
    mdd_state_t             state_reg;
    mdd_state_t             state_next;

    // input register
    logic                   item_valid_reg;
    logic                   item_cmd_reg;
    logic [BYTE_W-1:0]      item_byte_reg;

    // output register
    logic                   res_valid_reg;
    mdd_result_t            res_reg;

    logic                   step_res_valid;
    mdd_result_t            step_res;
    logic                   step_go;

    // the item is processed once the output register is free or draining
    assign step_go     = item_valid_reg && (!res_valid_reg || out_ch.ready);
    assign in_ch.ready = !item_valid_reg || step_go;

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker  <= START_MARKER_RST;
            cfg_reg.stop_marker   <= STOP_MARKER_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_TICKS_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_MARKER:  cfg_reg.start_marker  <= cfg_data;
                REG_STOP_MARKER:   cfg_reg.stop_marker   <= cfg_data;
                REG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_data[TICK_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            item_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            item_cmd_reg  <= in_ch.cmd;
            item_byte_reg <= in_ch.rx_byte;
        end
    end

    mdd_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .cmd        (item_cmd_reg),
        .rx_byte    (item_byte_reg),
        .state_next (state_next),
        .res_valid  (step_res_valid),
        .res        (step_res)
    );

    // frame state advances once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RST;
        end
        else if (step_go)
        begin
            state_reg <= state_next;
        end
    end

    // result register, loaded when an item yields a result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (step_go)
        begin
            res_valid_reg <= step_res_valid;
        end
        else if (out_ch.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_go && step_res_valid)
        begin
            res_reg <= step_res;
        end
    end

    assign out_ch.valid        = res_valid_reg;
    assign out_ch.kind         = res_reg.kind;
    assign out_ch.payload_byte = res_reg.payload_byte;
    assign out_ch.frame_length = res_reg.frame_length;

endmodule

>>> test/marker_delimited_deframer_top_tb.sv
`timescale 1ns / 100ps

module marker_delimited_deframer_top_tb;
    import mdd_pkg::*;

    // index past the end of the register list, writes to it must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
    // cycles allowed for items with no result to drain from the pipeline
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 110;

    // tracks frame state, predicts results and checks them in order
    class deframe_scoreboard;
        logic [MARKER_W-1:0]  start_marker;
        logic [MARKER_W-1:0]  stop_marker;
        logic [TICK_W-1:0]    timeout_ticks;
        bit                   in_frame;
        logic [HISTORY_W-1:0] recent_bytes;
        int unsigned          held_count;
        int unsigned          payload_count;
        int unsigned          tick_count;
        mdd_result_t          pending_results[$];
        int unsigned          fail_count;

        function new();
            start_marker  = START_MARKER_RST;
            stop_marker   = STOP_MARKER_RST;
            timeout_ticks = TIMEOUT_TICKS_RST;
            fail_count    = 0;
            restart_hunt();
        endfunction

        function void restart_hunt();
            in_frame      = 1'b0;
            recent_bytes  = '0;
            held_count    = 0;
            payload_count = 0;
            tick_count    = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] reg_index,
                                logic [CFG_DATA_W-1:0] cfg_value);
            case (reg_index)
                REG_START_MARKER:  start_marker  = cfg_value;
                REG_STOP_MARKER:   stop_marker   = cfg_value;
                REG_TIMEOUT_TICKS: timeout_ticks = cfg_value[TICK_W-1:0];
                default: ;
            endcase
        endfunction

        function void shift_in(logic [BYTE_W-1:0] rx_byte);
            recent_bytes = {recent_bytes[HISTORY_W-BYTE_W-1:0], rx_byte};
            if (held_count < 3)
                held_count++;
        endfunction

        function void add_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                 int unsigned frame_len);
            mdd_result_t res;
            res.kind         = kind;
            res.payload_byte = data;
            res.frame_length = LEN_W'(frame_len);
            pending_results.push_back(res);
        endfunction

        function void deframe_item(logic cmd, logic [BYTE_W-1:0] rx_byte);
            logic [MARKER_W-1:0] window;
            int unsigned         frame_len;
            if (cmd == CMD_TICK)
            begin
                if (tick_count < TICK_MAX)
                    tick_count++;
                if (tick_count >= timeout_ticks)
                begin
                    restart_hunt();
                    add_result(KIND_TIMEOUT, '0, 0);
                end
                return;
            end
            window = {recent_bytes, rx_byte};
            if (!in_frame)
            begin
                if (held_count == 3 && window == start_marker)
                begin
                    in_frame      = 1'b1;
                    recent_bytes  = '0;
                    held_count    = 0;
                    payload_count = 0;
                end
                else
                    shift_in(rx_byte);
                return;
            end
            if (held_count == 3 && window == stop_marker)
            begin
                frame_len = payload_count;
                restart_hunt();
                add_result(KIND_END, '0, frame_len);
                return;
            end
            if (held_count < 3)
            begin
                shift_in(rx_byte);
                return;
            end
            if (payload_count >= MAX_PAYLOAD)
            begin
                restart_hunt();
                add_result(KIND_OVERFLOW, '0, 0);
                return;
            end
            payload_count++;
            add_result(KIND_PAYLOAD, recent_bytes[HISTORY_W-1 -: BYTE_W], 0);
            shift_in(rx_byte);
        endfunction

        function void compare_field(string field_name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field_name, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(mdd_result_t got);
            mdd_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0h byte %0h len %0h",
                         $time, got.kind, got.payload_byte, got.frame_length);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("frame_length", want.frame_length, got.frame_length);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    mdd_in_if  in_ch();
    mdd_out_if out_ch();

    deframe_scoreboard frame_check;
    bit                send_gaps;
    bit                accept_stalls;
    int unsigned       items_sent;

    marker_delimited_deframer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case a handshake never completes
    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // every result transaction is checked against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            frame_check.check_result({out_ch.kind, out_ch.payload_byte, out_ch.frame_length});
    end

    // receiver: bursts of back-pressure between stretches of ready high
    initial
    begin
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (accept_stalls && $urandom_range(0, 5) == 0)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge clk);
            end
            @(negedge clk);
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(0, 15)) @(negedge clk);
        end
    end

    // one input transaction, with a random gap in front of it now and then;
    // valid stays high into the next item when there is no gap
    task automatic send_item(logic cmd, logic [BYTE_W-1:0] data);
        if (send_gaps && $urandom_range(0, 4) == 0)
        begin
            @(negedge clk);
            in_ch.valid   <= 1'b0;
            in_ch.cmd     <= 1'($urandom);
            in_ch.rx_byte <= BYTE_W'($urandom);
            repeat ($urandom_range(0, 10)) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= cmd;
        in_ch.rx_byte <= data;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        frame_check.deframe_item(cmd, data);
        items_sent++;
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] data);
        send_item(CMD_BYTE, data);
    endtask

    // the byte field is don't-care on a tick, so it gets noise
    task automatic send_tick();
        send_item(CMD_TICK, BYTE_W'($urandom));
    endtask

    // leading bytes of a marker, first byte from the top bits
    task automatic send_marker(logic [MARKER_W-1:0] marker, int n_bytes);
        for (int i = 0; i < n_bytes; i++)
            send_byte(marker[MARKER_W-1-BYTE_W*i -: BYTE_W]);
    endtask

    // frame body; some bytes are borrowed from the stop marker so that
    // partial stop patterns show up inside payloads
    task automatic send_payload(int n_bytes, int tick_pct, logic [MARKER_W-1:0] stop);
        for (int i = 0; i < n_bytes; i++)
        begin
            if ($urandom_range(0, 99) < tick_pct)
                send_tick();
            if ($urandom_range(0, 7) == 0)
                send_byte(stop[BYTE_W*$urandom_range(0, 3) +: BYTE_W]);
            else
                send_byte(BYTE_W'($urandom));
        end
    endtask

    // stop sending, let every predicted result arrive, then let any item
    // without a result drain out of the pipeline
    task automatic settle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (frame_check.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] reg_index, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= data;
        frame_check.write_reg(reg_index, data);
    endtask

    // writes go in only once the block is idle; junk above the timeout width
    // and a write to the unused index must both be ignored
    task automatic configure(logic [MARKER_W-1:0] start, logic [MARKER_W-1:0] stop,
                             logic [TICK_W-1:0] timeout);
        settle();
        write_reg(REG_START_MARKER, start);
        write_reg(REG_STOP_MARKER, stop);
        write_reg(REG_TIMEOUT_TICKS, {16'($urandom), timeout});
        write_reg(REG_UNUSED, $urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // mostly complete frames with random content, the rest noise, cut-off
    // start markers, false stop patterns and frames left open
    task automatic random_phase(int budget, int tick_pct);
        int unsigned         stop_at;
        int                  choice;
        int                  n_bytes;
        logic [MARKER_W-1:0] start;
        logic [MARKER_W-1:0] stop;
        start   = frame_check.start_marker;
        stop    = frame_check.stop_marker;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            choice  = $urandom_range(0, 99);
            n_bytes = $urandom_range(0, 12);
            if (choice < 55)
            begin
                send_marker(start, 4);
                send_payload(n_bytes, tick_pct, stop);
                send_marker(stop, 4);
            end
            else if (choice < 65)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    if ($urandom_range(0, 99) < tick_pct + 10)
                        send_tick();
                    else
                        send_byte(BYTE_W'($urandom));
                end
            end
            else if (choice < 75)
            begin
                send_marker(start, $urandom_range(1, 3));
                send_byte(BYTE_W'($urandom));
            end
            else if (choice < 87)
            begin
                send_marker(start, 4);
                send_payload(n_bytes, tick_pct, stop);
                send_marker(stop, $urandom_range(1, 3));
                send_payload($urandom_range(0, 4), tick_pct, stop);
                send_marker(stop, 4);
            end
            else
            begin
                // repeated start marker, frame left open for later items
                send_marker(start, 4);
                send_marker(start, 4);
                send_payload(n_bytes, tick_pct, stop);
            end
        end
    endtask

    // long frame with no ticks: exact limit or overflow
    task automatic long_frame(int n_bytes);
        send_marker(frame_check.start_marker, 4);
        send_payload(n_bytes, 0, frame_check.stop_marker);
        send_marker(frame_check.stop_marker, 4);
    endtask

    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.cmd     = CMD_BYTE;
        in_ch.rx_byte = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_START_MARKER;
        cfg_data      = '0;
        rst_n         = 1'b0;
        send_gaps     = 1'b1;
        accept_stalls = 1'b1;
        items_sent    = 0;
        frame_check   = new();
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // directed, register defaults: tick while hunting, byte extremes, start
        // only seen once three bytes are held, empty frame, then a hunt right
        // after the stop marker and a frame of four payload bytes
        send_tick();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_marker(START_MARKER_RST, 4);
        send_marker(STOP_MARKER_RST, 4);
        send_marker(START_MARKER_RST, 4);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(8'hA5);
        send_marker(STOP_MARKER_RST, 4);

        // short timeout: ticks inside a frame drop the held bytes on timeout
        configure(START_MARKER_RST, STOP_MARKER_RST, 16'd3);
        send_marker(START_MARKER_RST, 4);
        send_byte(8'h11);
        send_tick();
        send_byte(8'h22);
        send_byte(8'h33);
        send_tick();
        send_tick();

        // marker extremes, longest timeout, full-size frame and overflow
        configure(32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF);
        long_frame(MAX_PAYLOAD);
        long_frame(MAX_PAYLOAD + 1);
        random_phase(PHASE_ITEMS, 5);

        // opposite extremes, every tick times out
        configure(32'hFFFF_FFFF, 32'h0000_0000, 16'd1);
        random_phase(PHASE_ITEMS, 5);

        // zero timeout
        configure($urandom, $urandom, 16'd0);
        random_phase(PHASE_ITEMS, 3);

        // identical start and stop markers
        begin
            logic [MARKER_W-1:0] same_marker;
            same_marker = $urandom;
            configure(same_marker, same_marker, TICK_W'($urandom_range(5, 30)));
        end
        random_phase(PHASE_ITEMS, 8);

        configure($urandom, $urandom, TICK_W'($urandom_range(20, 200)));
        long_frame(MAX_PAYLOAD + 44);
        random_phase(PHASE_ITEMS, 10);

        // last stretch runs at full rate on both sides
        configure($urandom, $urandom, TICK_W'($urandom_range(1, 65535)));
        send_gaps     = 1'b0;
        accept_stalls = 1'b0;
        random_phase(PHASE_ITEMS, 5);

        settle();
        if (frame_check.pending_results.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived",
                     $time, frame_check.pending_results.size());
            frame_check.fail_count++;
        end
        if (frame_check.fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
